@@ rtl/core/bsp_pkg.sv @@
package bsp_pkg;

    localparam int VECTOR_BITS = 4096;
    localparam int STORE_BYTES = (VECTOR_BITS + 7) / 8;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int LEN_W       = ($clog2(VECTOR_BITS + 1) > 13) ? $clog2(VECTOR_BITS + 1) : 13;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_FIND  = 2'd1;
    localparam logic [1:0] OP_COUNT = 2'd2;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [8:0]  byte_index;
        logic [7:0]  byte_value;
        logic [11:0] start_bit;
        logic [12:0] end_bit;
        logic        end_to_used;
    } req_t;

    typedef struct packed {
        logic        found;
        logic [11:0] bit_index;
        logic [12:0] pop_count;
    } rsp_t;

    typedef struct packed {
        logic idle;
        logic done;
    } eng_status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } bsp_state_t;

    function automatic logic [7:0] byte_mask(input logic [2:0] lo, input logic [2:0] hi);
        logic [7:0] m;
        m = '0;
        for (int i = 0; i < 8; i++)
        begin
            m[i] = (3'(i) >= lo) && (3'(i) <= hi);
        end
        return m;
    endfunction

    function automatic logic [3:0] popcount8(input logic [7:0] b);
        logic [3:0] c;
        c = '0;
        for (int i = 0; i < 8; i++)
        begin
            c = c + 4'(b[i]);
        end
        return c;
    endfunction

    function automatic logic [2:0] lowest_set(input logic [7:0] b);
        logic [2:0] p;
        p = '0;
        for (int i = 7; i >= 0; i--)
        begin
            if (b[i])
            begin
                p = 3'(i);
            end
        end
        return p;
    endfunction

endpackage

@@ rtl/core/bsp_engine.sv @@
module bsp_engine (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  bsp_pkg::req_t        req,
    input  logic [12:0]          bits_used,
    input  logic                 take,
    output bsp_pkg::eng_status_t status,
    output bsp_pkg::rsp_t        res
);
    import bsp_pkg::*;

    localparam logic [LEN_W-1:0] VEC_LEN = LEN_W'(VECTOR_BITS);

    bsp_state_t        state_reg, state_next;
    logic              pend_reg, pend_next;
    logic              issue_done_reg, issue_done_next;
    logic              op_find_reg, op_find_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [ADDR_W-1:0] dbyte_reg, dbyte_next;
    logic [ADDR_W-1:0] start_byte_reg, start_byte_next;
    logic [ADDR_W-1:0] last_byte_reg, last_byte_next;
    logic [2:0]        start_lo_reg, start_lo_next;
    logic [2:0]        last_hi_reg, last_hi_next;
    logic [LEN_W-1:0]  acc_reg, acc_next;
    rsp_t              res_reg, res_next;
    logic [7:0]        rd_data_reg;

    logic [7:0]        store_mem [STORE_BYTES];

    logic [LEN_W-1:0]  used_len, end_sel, end_len, limit, start_ext, last_pos;
    logic              is_scan, empty, wr_en;
    logic [2:0]        lo, hi;
    logic [7:0]        masked;
    logic              hit, at_last, scan_stop;
    logic [LEN_W-1:0]  acc_sum;

    always_comb
    begin
        used_len  = (LEN_W'(bits_used) > VEC_LEN) ? VEC_LEN : LEN_W'(bits_used);
        end_sel   = req.end_to_used ? LEN_W'(bits_used) : LEN_W'(req.end_bit);
        end_len   = (end_sel > VEC_LEN) ? VEC_LEN : end_sel;
        limit     = (req.opcode == OP_FIND) ? used_len : end_len;
        start_ext = LEN_W'(req.start_bit);
        empty     = (start_ext >= limit);
        last_pos  = limit - LEN_W'(1);
        is_scan   = (req.opcode == OP_FIND) || (req.opcode == OP_COUNT);
        wr_en     = (state_reg == ST_IDLE) && start && (req.opcode == OP_WRITE)
                    && (32'(req.byte_index) < 32'(STORE_BYTES));
    end

    // shared byte unit: mask, popcount and priority pick on one stored byte
    always_comb
    begin
        lo        = (dbyte_reg == start_byte_reg) ? start_lo_reg : 3'd0;
        at_last   = (dbyte_reg == last_byte_reg);
        hi        = at_last ? last_hi_reg : 3'd7;
        masked    = rd_data_reg & byte_mask(lo, hi);
        hit       = (masked != 8'd0);
        acc_sum   = acc_reg + LEN_W'(popcount8(masked));
        scan_stop = pend_reg && ((op_find_reg && hit) || at_last);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = (is_scan && !empty) ? ST_SCAN : ST_DONE;
                end
            end
            ST_SCAN:
            begin
                if (scan_stop)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        pend_next       = 1'b0;
        issue_done_next = issue_done_reg;
        op_find_next    = op_find_reg;
        addr_next       = addr_reg;
        dbyte_next      = dbyte_reg;
        start_byte_next = start_byte_reg;
        last_byte_next  = last_byte_reg;
        start_lo_next   = start_lo_reg;
        last_hi_next    = last_hi_reg;
        acc_next        = acc_reg;
        res_next        = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    op_find_next    = (req.opcode == OP_FIND);
                    start_byte_next = ADDR_W'(start_ext >> 3);
                    start_lo_next   = start_ext[2:0];
                    last_byte_next  = ADDR_W'(last_pos >> 3);
                    last_hi_next    = last_pos[2:0];
                    addr_next       = ADDR_W'(start_ext >> 3);
                    issue_done_next = 1'b0;
                    acc_next        = '0;
                    res_next        = '0;
                end
            end
            ST_SCAN:
            begin
                if (!issue_done_reg)
                begin
                    pend_next  = 1'b1;
                    dbyte_next = addr_reg;
                    if (addr_reg == last_byte_reg)
                    begin
                        issue_done_next = 1'b1;
                    end
                    else
                    begin
                        addr_next = addr_reg + ADDR_W'(1);
                    end
                end
                if (pend_reg)
                begin
                    if (op_find_reg)
                    begin
                        if (hit)
                        begin
                            res_next.found     = 1'b1;
                            res_next.bit_index = 12'({dbyte_reg, lowest_set(masked)});
                        end
                    end
                    else
                    begin
                        acc_next = acc_sum;
                        if (at_last)
                        begin
                            res_next.pop_count = 13'(acc_sum);
                        end
                    end
                end
            end
            ST_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            pend_reg       <= 1'b0;
            issue_done_reg <= 1'b1;
        end
        else
        begin
            state_reg      <= state_next;
            pend_reg       <= pend_next;
            issue_done_reg <= issue_done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_find_reg    <= op_find_next;
        addr_reg       <= addr_next;
        dbyte_reg      <= dbyte_next;
        start_byte_reg <= start_byte_next;
        last_byte_reg  <= last_byte_next;
        start_lo_reg   <= start_lo_next;
        last_hi_reg    <= last_hi_next;
        acc_reg        <= acc_next;
        res_reg        <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[ADDR_W'(req.byte_index)] <= req.byte_value;
        end
        rd_data_reg <= store_mem[addr_reg];
    end

    assign status.idle = (state_reg == ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign res         = res_reg;

endmodule

@@ rtl/core/bitmap_scan_popcount.sv @@
// channel   direction  handshake              payload
// req       in         req_valid / req_ready  bsp_pkg::req_t
// rsp       out        rsp_valid / rsp_ready  bsp_pkg::rsp_t
// apb       in         psel, penable, pready  paddr, pwdata, prdata (bits_used at 0x0)
//
// Find or count: stored bytes are read and checked in turn, and the result is registered
// in the engine and then in the output register; a find stops at the byte holding the hit.
// One store read per cycle sets the pace. Write, unused opcode or empty range: no scan.
// req_ready is low while an item is in work; a waiting result in the output
// register does not block the next transfer until the following result is due.
// Reset clears control state and bits_used; store contents stay undefined until written.
module bitmap_scan_popcount (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bsp_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bsp_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import bsp_pkg::*;

    localparam logic [2:0] ADDR_BITS_USED = 3'h0;

    logic [12:0] bits_used_reg;
    logic        rsp_valid_reg, rsp_valid_next;
    rsp_t        rsp_reg, rsp_next;
    eng_status_t eng_status;
    rsp_t        eng_res;
    logic        start, take;

    assign pready    = 1'b1;
    assign prdata    = (paddr == ADDR_BITS_USED) ? 32'(bits_used_reg) : 32'd0;
    assign req_ready = eng_status.idle;
    assign start     = req_valid && req_ready;
    assign take      = eng_status.done && (!rsp_valid_reg || rsp_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_used_reg <= '0;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_BITS_USED))
        begin
            bits_used_reg <= pwdata[12:0];
        end
    end

    bsp_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .req       (req),
        .bits_used (bits_used_reg),
        .take      (take),
        .status    (eng_status),
        .res       (eng_res)
    );

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        rsp_next       = rsp_reg;
        if (take)
        begin
            rsp_valid_next = 1'b1;
            rsp_next       = eng_res;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/core/bsp_checker.sv @@
module bsp_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input bsp_pkg::rsp_t rsp
);

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp changed while stalled");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("req_ready high right after a transfer");

    a_not_found_index: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.found |-> rsp.bit_index == 12'd0)
        else $error("bit_index set without found");

    a_found_no_count: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.found |-> rsp.pop_count == 13'd0)
        else $error("pop_count set on a find result");

endmodule

bind bitmap_scan_popcount bsp_checker u_bsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

@@ bench/bitmap_scan_popcount_tb.sv @@
module bitmap_scan_popcount_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bsp_pkg::*;

    localparam int         REQ_W          = $bits(req_t);
    localparam logic [1:0] OP_UNUSED      = 2'd3;
    localparam logic [2:0] ADDR_BITS_USED = 3'd0;
    localparam int         WATCHDOG_LIMIT = 20000;
    localparam int         DRAIN_CYCLES   = 600;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        req_valid = 1'b0;
    logic        req_ready;
    req_t        req       = '0;
    logic        rsp_valid;
    logic        rsp_ready = 1'b0;
    rsp_t        rsp;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    req_t        pending_req_q[$];
    rsp_t        expected_rsp_q[$];
    logic [7:0]  mirror_bytes [STORE_BYTES];
    logic [12:0] mirror_bits_used = '0;
    rsp_t        want;

    int issued_count  = 0;
    int checked_count = 0;
    int fail_count    = 0;
    int stall_cycles  = 0;
    int send_idle_pct = 0;
    int rsp_stall_pct = 0;

    bitmap_scan_popcount dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic rsp_t scan_result(input req_t r);
        rsp_t o;
        int   lim;
        int   i;
        o = '0;
        case (r.opcode)
            OP_WRITE:
            begin
                mirror_bytes[r.byte_index] = r.byte_value;
            end
            OP_FIND:
            begin
                lim = int'(mirror_bits_used);
                if (lim > VECTOR_BITS)
                begin
                    lim = VECTOR_BITS;
                end
                for (i = int'(r.start_bit); i < lim && !o.found; i++)
                begin
                    if (mirror_bytes[i / 8][i % 8])
                    begin
                        o.found     = 1'b1;
                        o.bit_index = 12'(i);
                    end
                end
            end
            OP_COUNT:
            begin
                lim = r.end_to_used ? int'(mirror_bits_used) : int'(r.end_bit);
                if (lim > VECTOR_BITS)
                begin
                    lim = VECTOR_BITS;
                end
                for (i = int'(r.start_bit); i < lim; i++)
                begin
                    if (mirror_bytes[i / 8][i % 8])
                    begin
                        o.pop_count = o.pop_count + 13'd1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        return o;
    endfunction

    function automatic req_t op_write(input int idx, input int value);
        req_t r;
        r            = REQ_W'({$urandom, $urandom});
        r.opcode     = OP_WRITE;
        r.byte_index = 9'(idx);
        r.byte_value = 8'(value);
        return r;
    endfunction

    function automatic req_t op_find(input int start);
        req_t r;
        r           = REQ_W'({$urandom, $urandom});
        r.opcode    = OP_FIND;
        r.start_bit = 12'(start);
        return r;
    endfunction

    function automatic req_t op_count(input int start, input int stop, input bit to_used);
        req_t r;
        r             = REQ_W'({$urandom, $urandom});
        r.opcode      = OP_COUNT;
        r.start_bit   = 12'(start);
        r.end_bit     = 13'(stop);
        r.end_to_used = to_used;
        return r;
    endfunction

    function automatic logic [7:0] store_byte(input bit sparse);
        if (sparse)
        begin
            return ($urandom_range(15) == 0) ? 8'(1 << $urandom_range(7)) : 8'h00;
        end
        return ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom);
    endfunction

    function automatic req_t random_item(input bit sparse);
        req_t r;
        int   pick;
        r    = REQ_W'({$urandom, $urandom});
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            r.opcode = OP_WRITE;
        end
        else if (pick < 60)
        begin
            r.opcode = OP_FIND;
        end
        else if (pick < 95)
        begin
            r.opcode = OP_COUNT;
        end
        else
        begin
            r.opcode = OP_UNUSED;
        end
        if (sparse)
        begin
            r.byte_value = store_byte(1'b1);
        end
        pick = $urandom_range(9);
        if (pick < 4)
        begin
            r.end_bit = 13'(r.start_bit + $urandom_range(64));
        end
        else if (pick < 5)
        begin
            r.end_bit = 13'(VECTOR_BITS);
        end
        r.end_to_used = ($urandom_range(3) == 0);
        return r;
    endfunction

    task automatic queue_item(input req_t r);
        pending_req_q.push_back(r);
        issued_count++;
    endtask

    task automatic fill_store(input bit sparse);
        for (int b = 0; b < STORE_BYTES; b++)
        begin
            queue_item(op_write(b, store_byte(sparse)));
        end
    endtask

    task automatic wait_idle;
        do
        begin
            @(posedge clk);
        end
        while (checked_count != issued_count);
    endtask

    task automatic apb_write(input logic [12:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS_USED;
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        mirror_bits_used = value;
    endtask

    // driver: hold the payload until the transfer, then advance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                expected_rsp_q.push_back(scan_result(req));
            end
            if (!req_valid || req_ready)
            begin
                if (pending_req_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    req       <= pending_req_q.pop_front();
                    req_valid <= 1'b1;
                end
                else
                begin
                    req_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_ready     <= 1'b0;
            checked_count <= 0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                checked_count <= checked_count + 1;
                if (expected_rsp_q.size() == 0)
                begin
                    $error("unexpected transfer: found %0d bit_index %0d pop_count %0d",
                           rsp.found, rsp.bit_index, rsp.pop_count);
                    fail_count++;
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.found !== want.found)
                    begin
                        $error("found: expected %0d, got %0d", want.found, rsp.found);
                        fail_count++;
                    end
                    if (rsp.bit_index !== want.bit_index)
                    begin
                        $error("bit_index: expected %0d, got %0d", want.bit_index,
                               rsp.bit_index);
                        fail_count++;
                    end
                    if (rsp.pop_count !== want.pop_count)
                    begin
                        $error("pop_count: expected %0d, got %0d", want.pop_count,
                               rsp.pop_count);
                        fail_count++;
                    end
                end
            end
            rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= WATCHDOG_LIMIT)
            begin
                $display("bitmap_scan_popcount_tb: FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        logic [12:0] used_len;
        int          n_random;
        bit          sparse;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        for (int phase = 0; phase < 9; phase++)
        begin
            sparse = 1'b0;
            case (phase)
                0:       begin used_len = 13'd4096; n_random = 0;  end
                1:       begin used_len = 13'd3000; n_random = 0;  end
                2:       begin used_len = 13'd0;    n_random = 8;  end
                3:       begin used_len = 13'd1;    n_random = 8;  end
                4:       begin used_len = 13'd4095; n_random = 10; sparse = 1'b1; end
                5:       begin used_len = 13'd8191; n_random = 10; sparse = 1'b1; end
                default: begin used_len = 13'($urandom_range(4096)); n_random = 8; end
            endcase
            wait_idle();
            case (phase % 4)
                0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
                1:       begin send_idle_pct = 80; rsp_stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  rsp_stall_pct = 80; end
                default: begin send_idle_pct = 15; rsp_stall_pct = 15; end
            endcase
            apb_write(used_len);

            if (phase == 0)
            begin
                fill_store(1'b0);
                queue_item(op_write(0, 8'h00));
                queue_item(op_write(1, 8'h80));
                queue_item(op_write(STORE_BYTES - 1, 8'hFF));
                queue_item(op_find(0));
                queue_item(op_find(4095));
                queue_item(op_count(0, 4096, 1'b0));
                queue_item(op_count(0, 8191, 1'b0));
                queue_item(op_count(0, 0, 1'b0));
                queue_item(op_count(100, 50, 1'b0));
                queue_item(op_count(4095, 4096, 1'b0));
                queue_item(op_count(7, 16, 1'b1));
                queue_item(random_item(1'b0) ^ REQ_W'(0) | {OP_UNUSED, {(REQ_W - 2){1'b0}}});
                queue_item(op_write(STORE_BYTES - 1, 8'h00));
                queue_item(op_find(4088));
                queue_item(op_find(4095));
            end
            else if (phase == 1)
            begin
                queue_item(op_write(374, 8'h81));
                queue_item(op_find(2999));
                queue_item(op_find(3000));
                queue_item(op_find(4095));
                queue_item(op_count(2990, 0, 1'b1));
                queue_item(op_count(2990, 4096, 1'b0));
                queue_item(op_count(3000, 3000, 1'b1));
            end

            for (int k = 0; k < n_random; k++)
            begin
                queue_item(random_item(sparse));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && expected_rsp_q.size() == 0)
        begin
            $display("bitmap_scan_popcount_tb: PASS");
        end
        else
        begin
            $display("bitmap_scan_popcount_tb: FAIL");
        end
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/bsp_pkg.sv
rtl/core/bsp_engine.sv
rtl/core/bitmap_scan_popcount.sv
rtl/core/bsp_checker.sv
bench/bitmap_scan_popcount_tb.sv
